### design/wsm_pkg.sv
// Shared types and constants for the window sum max finder.
package wsm_pkg;

   localparam int SUM_OUT_W  = 20;
   localparam int ROW_OUT_W  = 12;
   localparam int COL_OUT_W  = 10;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam int ROWS_CSR_W = 13;
   localparam int COLS_CSR_W = 11;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_COLS = 1'b1;

   typedef struct packed {
      logic                 interior;
      logic                 frame_end;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
   } item_ctrl_type;

   typedef struct packed {
      logic                 found;
      logic [COL_OUT_W-1:0] best_col;
      logic [ROW_OUT_W-1:0] best_row;
      logic [SUM_OUT_W-1:0] best_sum;
   } result_type;

endpackage

### design/wsm_line_buf.sv
// Two line stores with registered read and same-cycle write bypass.
module wsm_line_buf #(
   parameter int VALUE_WIDTH = 16,
   parameter int MAX_COLS    = 1024,
   parameter int ADDR_W      = 10
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_upper,
   input  logic [VALUE_WIDTH-1:0] wr_middle,
   output logic [VALUE_WIDTH-1:0] rd_upper,
   output logic [VALUE_WIDTH-1:0] rd_middle
);

   logic [VALUE_WIDTH-1:0] mem_upper  [MAX_COLS];
   logic [VALUE_WIDTH-1:0] mem_middle [MAX_COLS];

   logic [VALUE_WIDTH-1:0] rd_upper_ff;
   logic [VALUE_WIDTH-1:0] rd_middle_ff;
   logic [VALUE_WIDTH-1:0] byp_upper_ff;
   logic [VALUE_WIDTH-1:0] byp_middle_ff;
   logic                   byp_ff;
   logic                   byp_in;

   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_upper[wr_addr]  <= wr_upper;
         mem_middle[wr_addr] <= wr_middle;
      end
      if (rd_en) begin
         rd_upper_ff  <= mem_upper[rd_addr];
         rd_middle_ff <= mem_middle[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_ff        <= byp_in;
         byp_upper_ff  <= wr_upper;
         byp_middle_ff <= wr_middle;
      end
   end

   assign rd_upper  = byp_ff ? byp_upper_ff  : rd_upper_ff;
   assign rd_middle = byp_ff ? byp_middle_ff : rd_middle_ff;

endmodule

### design/wsm_search.sv
// Column sums, window sum and running maximum search.
module wsm_search #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [VALUE_WIDTH-1:0] cur_value,
   input  logic [VALUE_WIDTH-1:0] upper,
   input  logic [VALUE_WIDTH-1:0] middle,
   input  wsm_pkg::item_ctrl_type ctrl,
   output wsm_pkg::result_type    result
);

   import wsm_pkg::*;

   localparam int COLSUM_W = VALUE_WIDTH + 2;
   localparam int SUM_W    = VALUE_WIDTH + 4;

   logic [COLSUM_W-1:0]        cs0_ff, cs0_in;
   logic [COLSUM_W-1:0]        cs1_ff, cs1_in;
   logic [SUM_W-1:0]           max_ff, max_in;
   logic [ROW_OUT_W-1:0]       row_ff, row_in;
   logic [COL_OUT_W-1:0]       col_ff, col_in;
   logic                       have_ff, have_in;
   logic [COLSUM_W-1:0]        col_sum;
   logic [SUM_W-1:0]           win_sum;
   logic                       upd;
   logic [SUM_W-1:0]           new_max;
   logic [ROW_OUT_W-1:0]       new_row;
   logic [COL_OUT_W-1:0]       new_col;
   logic [SUM_W+SUM_OUT_W-1:0] sum_ext;

   always_comb begin
      col_sum = COLSUM_W'(upper) + COLSUM_W'(middle) + COLSUM_W'(cur_value);
      win_sum = SUM_W'(col_sum) + SUM_W'(cs0_ff) + SUM_W'(cs1_ff);
      upd     = ctrl.interior && (!have_ff || (win_sum > max_ff));
      new_max = upd ? win_sum : max_ff;
      new_row = upd ? ctrl.row : row_ff;
      new_col = upd ? ctrl.col : col_ff;
      sum_ext = {{SUM_OUT_W{1'b0}}, new_max};

      result.found    = have_ff || upd;
      result.best_sum = sum_ext[SUM_OUT_W-1:0];
      result.best_row = new_row;
      result.best_col = new_col;

      cs0_in  = cs0_ff;
      cs1_in  = cs1_ff;
      max_in  = max_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      have_in = have_ff;
      if (fire) begin
         if (ctrl.frame_end) begin
            cs0_in  = '0;
            cs1_in  = '0;
            max_in  = '0;
            row_in  = '0;
            col_in  = '0;
            have_in = 1'b0;
         end else begin
            cs0_in  = cs1_ff;
            cs1_in  = col_sum;
            max_in  = new_max;
            row_in  = new_row;
            col_in  = new_col;
            have_in = have_ff || upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs0_ff  <= '0;
         cs1_ff  <= '0;
         max_ff  <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
         have_ff <= 1'b0;
      end else begin
         cs0_ff  <= cs0_in;
         cs1_ff  <= cs1_in;
         max_ff  <= max_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         have_ff <= have_in;
      end
   end

endmodule

### design/window_sum_max_finder_top.sv
// Finds the 3x3 window with the largest sum in a matrix streamed in row-major order.
//
// Requests on req_* carry one matrix element each, in row-major order; the
// matrix size comes from the csr_* write port (index 0 rows, index 1 columns,
// a zero counts as one, larger values saturate to MAX_ROWS / MAX_COLS).
// One request is taken every cycle while req_tready is high. A request
// enters an input stage that reads both line stores; from that stage the
// window sum is formed and compared against the running maximum. After the
// last element of a matrix one response is presented on rsp_* from the
// output register, loaded when that element leaves the input stage:
// best sum, centre row and column in rsp_tdata, and the found flag in
// rsp_tuser. Ties keep the first window in row-major order.
// The response waits in an output register while rsp_tready is low; requests
// keep flowing until a further matrix end meets that full register, which
// then holds req_tready low until the response is taken.
// Reset clears the counters, the window, the search and the output valid
// flag and sets both dimensions to 3; the line stores keep their contents.
module window_sum_max_finder_top #(
   parameter int VALUE_WIDTH = 16,
   parameter int MAX_COLS    = 1024,
   parameter int MAX_ROWS    = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       req_tdata,  // cell_value
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [47:0]                            rsp_tdata,  // best_sum, best_row, best_col
   output logic                                   rsp_tuser,  // found
   input  logic                                   csr_we,
   input  logic [wsm_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [wsm_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   import wsm_pkg::*;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_CW = $clog2(MAX_COLS + 1);
   localparam int ROW_CW = $clog2(MAX_ROWS + 1);
   localparam int TDATA_W = SUM_OUT_W + ROW_OUT_W + COL_OUT_W;

   logic [COL_CW-1:0]      cols_lim_ff, cols_lim_in;
   logic [ROW_CW-1:0]      rows_lim_ff, rows_lim_in;
   logic [COL_W-1:0]       col_count_ff, col_count_in;
   logic [ROW_W-1:0]       row_count_ff, row_count_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [VALUE_WIDTH-1:0] s1_cell_ff;
   logic [COL_W-1:0]       s1_addr_ff;
   item_ctrl_type          s1_ctrl_ff, ctrl_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff;

   logic                   accept;
   logic                   fire;
   logic                   row_end;
   logic                   frame_end;
   logic [COL_CW:0]        col_inc;
   logic [ROW_CW:0]        row_inc;
   logic [ROW_W-1:0]       row_m1;
   logic [COL_W-1:0]       col_m1;
   logic [ROW_W+ROW_OUT_W-1:0] row_ext;
   logic [COL_W+COL_OUT_W-1:0] col_ext;
   logic [VALUE_WIDTH-1:0] req_cell;
   logic [VALUE_WIDTH-1:0] upper;
   logic [VALUE_WIDTH-1:0] middle;
   result_type             result;
   logic [ROWS_CSR_W-1:0]  rows_wr;
   logic [COLS_CSR_W-1:0]  cols_wr;

   // configuration, clamped on write
   always_comb begin
      rows_wr     = csr_wdata[ROWS_CSR_W-1:0];
      cols_wr     = csr_wdata[COLS_CSR_W-1:0];
      rows_lim_in = rows_lim_ff;
      cols_lim_in = cols_lim_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_NUM_ROWS: begin
               if (rows_wr == '0) rows_lim_in = ROW_CW'(1);
               else if (rows_wr > MAX_ROWS) rows_lim_in = ROW_CW'(MAX_ROWS);
               else rows_lim_in = ROW_CW'(rows_wr);
            end
            CSR_NUM_COLS: begin
               if (cols_wr == '0) cols_lim_in = COL_CW'(1);
               else if (cols_wr > MAX_COLS) cols_lim_in = COL_CW'(MAX_COLS);
               else cols_lim_in = COL_CW'(cols_wr);
            end
            default: begin
               rows_lim_in = rows_lim_ff;
            end
         endcase
      end
   end

   // handshake
   always_comb begin
      fire         = s1_valid_ff && (!s1_ctrl_ff.frame_end || !out_valid_ff || rsp_tready);
      req_tready   = !s1_valid_ff || fire;
      accept       = req_tvalid && req_tready;
      s1_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
      if (fire && s1_ctrl_ff.frame_end) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   // position counters
   always_comb begin
      req_cell  = req_tdata[VALUE_WIDTH-1:0];
      col_inc   = (COL_CW+1)'(col_count_ff) + (COL_CW+1)'(1);
      row_inc   = (ROW_CW+1)'(row_count_ff) + (ROW_CW+1)'(1);
      row_end   = col_inc >= (COL_CW+1)'(cols_lim_ff);
      frame_end = row_end && (row_inc >= (ROW_CW+1)'(rows_lim_ff));
      row_m1    = row_count_ff - ROW_W'(1);
      col_m1    = col_count_ff - COL_W'(1);
      row_ext   = {{ROW_OUT_W{1'b0}}, row_m1};
      col_ext   = {{COL_OUT_W{1'b0}}, col_m1};

      ctrl_in.interior  = (row_count_ff >= ROW_W'(2)) && (col_count_ff >= COL_W'(2));
      ctrl_in.frame_end = frame_end;
      ctrl_in.row       = row_ext[ROW_OUT_W-1:0];
      ctrl_in.col       = col_ext[COL_OUT_W-1:0];

      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         priority if (frame_end) begin
            col_count_in = '0;
            row_count_in = '0;
         end else if (row_end) begin
            col_count_in = '0;
            row_count_in = row_count_ff + ROW_W'(1);
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_lim_ff  <= ROW_CW'(3);
         cols_lim_ff  <= COL_CW'(3);
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rows_lim_ff  <= rows_lim_in;
         cols_lim_ff  <= cols_lim_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff <= req_cell;
         s1_addr_ff <= col_count_ff;
         s1_ctrl_ff <= ctrl_in;
      end
      if (fire && s1_ctrl_ff.frame_end) begin
         out_ff <= result;
      end
   end

   wsm_line_buf #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_COLS    (MAX_COLS),
      .ADDR_W      (COL_W)
   ) u_line_buf (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (col_count_ff),
      .wr_en     (fire),
      .wr_addr   (s1_addr_ff),
      .wr_upper  (middle),
      .wr_middle (s1_cell_ff),
      .rd_upper  (upper),
      .rd_middle (middle)
   );

   wsm_search #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .cur_value (s1_cell_ff),
      .upper     (upper),
      .middle    (middle),
      .ctrl      (s1_ctrl_ff),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(48-TDATA_W)'(0), out_ff.best_col, out_ff.best_row, out_ff.best_sum};
   assign rsp_tuser  = out_ff.found;

endmodule

### design/wsm_checker.sv
// Port-level checks on the response channel, bound to the top level.
module wsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 48'd0))
      else $error("empty search with non-zero result");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("response changed while stalled");

endmodule

bind window_sum_max_finder_top wsm_checker u_wsm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
